// File: sv/odither_pkg.sv
package odither_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_DEPTH      = 2'd0;
    localparam logic [1:0] CFG_MODE       = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND = 2'd2;

    // Dither modes
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_BAYER2 = 2'd1;
    localparam logic [1:0] MODE_BAYER4 = 2'd2;

    // Depth limits and reset value
    localparam logic [2:0] DEPTH_MIN   = 3'd1;
    localparam logic [2:0] DEPTH_MAX   = 3'd5;

    // 1.0 in unsigned 16.16, as a 17-bit clamped level
    localparam logic [16:0] FULL_SCALE = 17'h10000;

    // Ordered dither threshold matrices, row-major
    localparam logic [3:0] BAYER4 [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };
    localparam logic [1:0] BAYER2 [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

    // Per-pixel control shared by the three channel quantizers
    typedef struct packed {
        logic [2:0] depth;
        logic [1:0] mode;
        logic [3:0] thresh;
    } chan_ctrl_t;

    // Top depth bits of a 5-bit channel
    function automatic logic [4:0] depth_mask(input logic [2:0] depth);
        logic [4:0] mask;
        unique case (depth)
            3'd1:    mask = 5'b10000;
            3'd2:    mask = 5'b11000;
            3'd3:    mask = 5'b11100;
            3'd4:    mask = 5'b11110;
            default: mask = 5'b11111;
        endcase
        return mask;
    endfunction

    // Weight of the lowest kept bit in a 5-bit channel
    function automatic logic [4:0] depth_lsb(input logic [2:0] depth);
        logic [4:0] lsb;
        unique case (depth)
            3'd1:    lsb = 5'b10000;
            3'd2:    lsb = 5'b01000;
            3'd3:    lsb = 5'b00100;
            3'd4:    lsb = 5'b00010;
            default: lsb = 5'b00001;
        endcase
        return lsb;
    endfunction

    // Threshold for the pixel position under the given mode
    function automatic logic [3:0] bayer_thresh(input logic [1:0] mode,
                                                input logic [1:0] row,
                                                input logic [1:0] col);
        logic [3:0] th;
        if (mode == MODE_BAYER4)
            th = BAYER4[{row, col}];
        else
            th = {2'b00, BAYER2[{row[0], col[0]}]};
        return th;
    endfunction

endpackage

// File: sv/ordered_dither_rgb555_core.sv
// Pipeline: an accepted input beat passes through the input register, then the result
// register, before out_valid rises.
// Throughput: one pixel per cycle while out_ready stays high; a new beat is taken
// whenever the input register is empty or can move forward into the result register.
// Reset: all valid flags cleared; color_depth returns to 5, dither_mode to off,
// background_color to 0. Payload registers are not reset.
module ordered_dither_rgb555_core (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    // pixel input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               hit,
    input  logic signed [31:0] red_level,
    input  logic signed [31:0] green_level,
    input  logic signed [31:0] blue_level,
    input  logic [7:0]         column,
    input  logic [7:0]         row,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [14:0]        pixel_color
);

    logic [2:0]  depth_reg;
    logic [1:0]  mode_reg;
    logic [14:0] background_reg;

    logic               s1_valid_reg;
    logic               s1_hit_reg;
    logic signed [31:0] s1_red_reg;
    logic signed [31:0] s1_green_reg;
    logic signed [31:0] s1_blue_reg;
    logic [1:0]         s1_col_reg;
    logic [1:0]         s1_row_reg;

    logic               out_valid_reg;
    logic [14:0]        color_reg;
    logic [14:0]        color_next;

    logic               s1_advance;
    logic [2:0]         depth_next;
    logic [1:0]         mode_next;
    logic [4:0]         mask;
    logic [4:0]         red_color;
    logic [4:0]         green_color;
    logic [4:0]         blue_color;

    odither_pkg::chan_ctrl_t ctrl;

    // Clamp register writes into their legal ranges
    always_comb
    begin
        if (cfg_data[2:0] < odither_pkg::DEPTH_MIN)
            depth_next = odither_pkg::DEPTH_MIN;
        else if (cfg_data[2:0] > odither_pkg::DEPTH_MAX)
            depth_next = odither_pkg::DEPTH_MAX;
        else
            depth_next = cfg_data[2:0];

        if (cfg_data[1:0] > odither_pkg::MODE_BAYER4)
            mode_next = odither_pkg::MODE_BAYER4;
        else
            mode_next = cfg_data[1:0];
    end

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= odither_pkg::DEPTH_MAX;
            mode_reg       <= odither_pkg::MODE_OFF;
            background_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                odither_pkg::CFG_DEPTH:      depth_reg      <= depth_next;
                odither_pkg::CFG_MODE:       mode_reg       <= mode_next;
                odither_pkg::CFG_BACKGROUND: background_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Pipeline handshake: advance when the result register is free or being drained
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;

    // Input register valid and result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_hit_reg   <= hit;
            s1_red_reg   <= red_level;
            s1_green_reg <= green_level;
            s1_blue_reg  <= blue_level;
            s1_col_reg   <= column[1:0];
            s1_row_reg   <= row[1:0];
        end
    end

    // Per-pixel control for the channel quantizers
    always_comb
    begin
        ctrl.depth  = depth_reg;
        ctrl.mode   = mode_reg;
        ctrl.thresh = odither_pkg::bayer_thresh(mode_reg, s1_row_reg, s1_col_reg);
    end

    odither_chan u_red (
        .level (s1_red_reg),
        .ctrl  (ctrl),
        .color (red_color)
    );

    odither_chan u_green (
        .level (s1_green_reg),
        .ctrl  (ctrl),
        .color (green_color)
    );

    odither_chan u_blue (
        .level (s1_blue_reg),
        .ctrl  (ctrl),
        .color (blue_color)
    );

    // Pick shaded color or background, posterizing background only when not dithering
    assign mask = odither_pkg::depth_mask(depth_reg);

    always_comb
    begin
        if (s1_hit_reg)
            color_next = {blue_color, green_color, red_color};
        else if (mode_reg == odither_pkg::MODE_OFF)
            color_next = background_reg & {mask, mask, mask};
        else
            color_next = background_reg;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
            color_reg <= color_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = color_reg;

    // Stored depth stays within 1 .. 5
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg >= odither_pkg::DEPTH_MIN && depth_reg <= odither_pkg::DEPTH_MAX)
        else $error("color depth register out of range");

    // Only the defined mode codes are stored
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= odither_pkg::MODE_BAYER4)
        else $error("dither mode register holds an unused code");

    // An empty result register never blocks input
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with the result register empty");

    // An accepted beat lands in the input register
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted beat lost at the input register");

    // A held beat moves to the output when the output is free
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_advance |=> out_valid_reg)
        else $error("beat lost between input and result registers");

endmodule

// File: sv/odither_chan.sv
module odither_chan (
    input  logic signed [31:0]        level,
    input  odither_pkg::chan_ctrl_t   ctrl,
    output logic [4:0]                color
);

    logic [16:0] lvl;
    logic [4:0]  mask;
    logic [4:0]  lsb;
    logic [4:0]  trunc_sat;
    logic [4:0]  aligned;
    logic [15:0] frac_sh;
    logic [3:0]  next_bits;
    logic        full;

    // Clamp the signed 16.16 level to 0 .. 1.0
    always_comb
    begin
        if (level[31])
            lvl = '0;
        else if (level[30:0] > {14'b0, odither_pkg::FULL_SCALE})
            lvl = odither_pkg::FULL_SCALE;
        else
            lvl = level[16:0];
    end

    assign mask = odither_pkg::depth_mask(ctrl.depth);
    assign lsb  = odither_pkg::depth_lsb(ctrl.depth);

    // Truncate to 5 bits, saturating full scale
    assign trunc_sat = lvl[16] ? 5'h1F : lvl[15:11];

    // Kept bits left-aligned, and the bits just below them at the top of frac_sh
    assign aligned   = lvl[15:11] & mask;
    assign full      = lvl[16] || (aligned == mask);
    assign frac_sh   = lvl[15:0] << ctrl.depth;
    assign next_bits = (ctrl.mode == odither_pkg::MODE_BAYER4) ? frac_sh[15:12]
                                                               : {2'b00, frac_sh[15:14]};

    // Select plain truncation or rounded-up dithered value
    always_comb
    begin
        if (ctrl.mode == odither_pkg::MODE_OFF)
            color = trunc_sat & mask;
        else if (full)
            color = mask;
        else if (next_bits >= ctrl.thresh)
            color = aligned + lsb;
        else
            color = aligned;
    end

endmodule
